FILE: hdl/grey_to_heat_colormap_top_assert.svh
// assertion macros for the grey to heat colormap block
// included by grey_to_heat_colormap_top.sv, no other dependencies
`ifndef GREY_TO_HEAT_COLORMAP_TOP_ASSERT_SVH
`define GREY_TO_HEAT_COLORMAP_TOP_ASSERT_SVH
`ifndef SYNTH
`define GTHC_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("grey_to_heat_colormap_top assertion failed");
`define GTHC_ASSERT_NEVER(lbl, ck, rn, expr) \
  `GTHC_ASSERT(lbl, ck, rn, !(expr))
`else
`define GTHC_ASSERT(lbl, ck, rn, prop)
`define GTHC_ASSERT_NEVER(lbl, ck, rn, expr)
`endif
`endif

FILE: hdl/gthc_pkg.sv
// shared types and fixed constants of the grey to heat colormap block
// no dependencies; used by grey_to_heat_colormap_top.sv
package gthc_pkg;

  // port word format, unsigned Q1.15
  localparam int IO_W    = 16;
  localparam int IO_FRAC = 15;

  typedef logic [IO_W-1:0] io_word_t;

  localparam io_word_t GREY_ONE = io_word_t'(32768);

  // three color channels, six register stages
  localparam int NUM_CHAN = 3;
  localparam int NUM_STG  = 6;

  // channel slots
  localparam int CH_0 = 0;
  localparam int CH_1 = 1;
  localparam int CH_2 = 2;

endpackage

FILE: hdl/grey_to_heat_colormap_top.sv
// grey to heat colormap: six stage pipeline, three quintic smoothstep channels
// depends on gthc_pkg.sv and grey_to_heat_colormap_top_assert.svh
//
// usage
// - input channel: in_valid, in_stall, in_grey (Q1.15, values above 1.0 saturate)
// - result channel: out_valid, out_stall, out_chan_0/1/2 (Q1.15, at most 32768)
// - an item is taken on a clock edge with valid high and stall low
// - an item passes the stage 0 to stage 5 registers in order on its way to out_valid
// - throughput is one item per cycle while out_stall is low; each stage holds at most one
//   multiplier depth per channel (t scaling, t^2 and t*(15-6t), t^3 and
//   q, t^3*q, final scale), which with the input stage sets the 6 stage depth
// - each stage has its own valid bit and loads when it is empty or the
//   stage after it moves, so bubbles are squeezed out on a stall
// - in_stall rises only when all six stages hold items and out_stall is high;
//   a stalled result holds its value
// - synchronous active low reset empties every stage; the data registers are not reset
// - FRAC_BITS sets the internal fraction width (8..24)
`include "grey_to_heat_colormap_top_assert.svh"

module grey_to_heat_colormap_top #(
  parameter int FRAC_BITS = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gthc_pkg::io_word_t in_grey,
  output logic              out_valid,
  input  logic              out_stall,
  output gthc_pkg::io_word_t out_chan_0,
  output gthc_pkg::io_word_t out_chan_1,
  output gthc_pkg::io_word_t out_chan_2
);

  localparam int FB  = FRAC_BITS;
  localparam int W   = FB + 1;       // values 0..ONE
  localparam int RW  = FB + 2;       // reciprocals up to 3.34
  localparam int QW  = FB + 4;       // polynomial terms up to 15
  localparam int IOW = gthc_pkg::IO_W;
  localparam int NC  = gthc_pkg::NUM_CHAN;
  localparam int NS  = gthc_pkg::NUM_STG;
  localparam int UP_SH = (FB >= gthc_pkg::IO_FRAC) ? FB - gthc_pkg::IO_FRAC : 0;
  localparam int DN_SH = (FB < gthc_pkg::IO_FRAC) ? gthc_pkg::IO_FRAC - FB : 0;

  // fixed point constants, rounded to nearest
  localparam logic [63:0] ONE_L  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] K03_L  = (64'd3 * ONE_L + 64'd5) / 64'd10;
  localparam logic [63:0] K05_L  = ONE_L / 64'd2;
  localparam logic [63:0] K07_L  = (64'd7 * ONE_L + 64'd5) / 64'd10;
  localparam logic [63:0] K09_L  = (64'd9 * ONE_L + 64'd5) / 64'd10;
  localparam logic [63:0] K11_L  = (64'd11 * ONE_L + 64'd5) / 64'd10;
  localparam logic [63:0] R03_L  = (64'd20 * ONE_L + 64'd3) / 64'd6;
  localparam logic [63:0] R07_L  = (64'd20 * ONE_L + 64'd7) / 64'd14;
  localparam logic [63:0] C15_L  = 64'd15 * ONE_L;
  localparam logic [63:0] C10_L  = 64'd10 * ONE_L;

  localparam logic [W-1:0]  ONE   = ONE_L[W-1:0];
  localparam logic [W-1:0]  K_0P3 = K03_L[W-1:0];
  localparam logic [W-1:0]  K_0P5 = K05_L[W-1:0];
  localparam logic [W-1:0]  K_0P7 = K07_L[W-1:0];
  localparam logic [W-1:0]  K_0P9 = K09_L[W-1:0];
  localparam logic [W-1:0]  K_1P1 = K11_L[W-1:0];
  localparam logic [RW-1:0] R_0P3 = R03_L[RW-1:0];
  localparam logic [RW-1:0] R_0P7 = R07_L[RW-1:0];
  localparam logic [QW-1:0] C_15  = C15_L[QW-1:0];
  localparam logic [QW-1:0] C_10  = C10_L[QW-1:0];

  // per item side data that rides along the polynomial stages
  typedef struct packed {
    logic         hi2;   // grey at or above 0.9
    logic         lo0;   // grey at or below 0.3
    logic [W-1:0] f2;    // channel 2 fade factor
    logic [W-1:0] sc0;   // grey in stage 0, channel 0 ramp factor later
  } side_t;

  // stage valid bits and ready chain
  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // stage 0: saturate grey, form numerators and the fade factor
  logic [IOW-1:0]   gin_sat;
  logic [W+IOW-1:0] g_wide;
  logic [W-1:0]     g;
  logic [W-1:0]     d11;
  logic [W+2:0]     d11x5;
  logic [W-1:0]     n_nxt [NC];
  logic             hi1_nxt;
  side_t            side0_nxt;
  logic [W-1:0]     s0_n_r [NC];
  logic             s0_hi1_r;
  side_t            s0_side_r;

  always_comb begin
    gin_sat = (in_grey > gthc_pkg::GREY_ONE) ? gthc_pkg::GREY_ONE : in_grey;
    g_wide  = ({{W{1'b0}}, gin_sat} >> DN_SH) << UP_SH;
    g       = g_wide[W-1:0];
    n_nxt[gthc_pkg::CH_2] = (g <= K_0P5) ? '0 : g - K_0P5;
    hi1_nxt = g > K_0P7;
    n_nxt[gthc_pkg::CH_1] = hi1_nxt ? ONE - g : g;
    n_nxt[gthc_pkg::CH_0] = ONE - g;
    d11     = K_1P1 - g;
    d11x5   = {3'b000, d11} + {1'b0, d11, 2'b00};
    side0_nxt.hi2 = g >= K_0P9;
    side0_nxt.lo0 = g <= K_0P3;
    side0_nxt.f2  = (d11x5 > {3'b000, ONE}) ? ONE : d11x5[W-1:0];
    side0_nxt.sc0 = g;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_n_r    <= n_nxt;
      s0_hi1_r  <= hi1_nxt;
      s0_side_r <= side0_nxt;
    end
  end

  // stage 1: scale the channel 1 and 2 numerators and the ramp factor by reciprocals, clamp t
  logic [W+RW-1:0] m2, m1, ms;
  logic [W-1:0]    t_nxt [NC];
  side_t           side1_nxt;
  logic [W-1:0]    s1_t_r [NC];
  side_t           s1_side_r;

  always_comb begin
    m2 = {{RW{1'b0}}, s0_n_r[gthc_pkg::CH_2]} * {{W{1'b0}}, R_0P3};
    m1 = {{RW{1'b0}}, s0_n_r[gthc_pkg::CH_1]} * {{W{1'b0}}, (s0_hi1_r ? R_0P3 : R_0P7)};
    ms = {{RW{1'b0}}, s0_side_r.sc0} * {{W{1'b0}}, R_0P3};
    t_nxt[gthc_pkg::CH_2] = (m2[W+RW-1:FB] > {2'b00, ONE}) ? ONE : m2[FB+W-1:FB];
    t_nxt[gthc_pkg::CH_1] = (m1[W+RW-1:FB] > {2'b00, ONE}) ? ONE : m1[FB+W-1:FB];
    t_nxt[gthc_pkg::CH_0] = s0_n_r[gthc_pkg::CH_0];
    side1_nxt     = s0_side_r;
    side1_nxt.sc0 = (ms[W+RW-1:FB] > {2'b00, ONE}) ? ONE : ms[FB+W-1:FB];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_t_r    <= t_nxt;
      s1_side_r <= side1_nxt;
    end
  end

  // stage 2: t squared and t*(15-6t) per channel
  logic [2*W-1:0]  sq [NC];
  logic [QW-1:0]   a15 [NC];
  logic [W+QW-1:0] ua [NC];
  logic [W-1:0]    tt_nxt [NC];
  logic [QW-1:0]   u_nxt [NC];
  logic [W-1:0]    s2_t_r [NC];
  logic [W-1:0]    s2_tt_r [NC];
  logic [QW-1:0]   s2_u_r [NC];
  side_t           s2_side_r;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      sq[c]     = {{W{1'b0}}, s1_t_r[c]} * {{W{1'b0}}, s1_t_r[c]};
      tt_nxt[c] = sq[c][FB+W-1:FB];
      a15[c]    = C_15 - ({1'b0, s1_t_r[c], 2'b00} + {2'b00, s1_t_r[c], 1'b0});
      ua[c]     = {{QW{1'b0}}, s1_t_r[c]} * {{W{1'b0}}, a15[c]};
      u_nxt[c]  = ua[c][FB+QW-1:FB];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_t_r    <= s1_t_r;
      s2_tt_r   <= tt_nxt;
      s2_u_r    <= u_nxt;
      s2_side_r <= s1_side_r;
    end
  end

  // stage 3: t cubed and q = 10 - t*(15-6t)
  logic [2*W-1:0] cb [NC];
  logic [W-1:0]   t3_nxt [NC];
  logic [QW-1:0]  q_nxt [NC];
  logic [W-1:0]   s3_t3_r [NC];
  logic [QW-1:0]  s3_q_r [NC];
  side_t          s3_side_r;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      cb[c]     = {{W{1'b0}}, s2_tt_r[c]} * {{W{1'b0}}, s2_t_r[c]};
      t3_nxt[c] = cb[c][FB+W-1:FB];
      q_nxt[c]  = C_10 - s2_u_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_t3_r   <= t3_nxt;
      s3_q_r    <= q_nxt;
      s3_side_r <= s2_side_r;
    end
  end

  // stage 4: smoothstep value t^3*q, clamped to one
  logic [W+QW-1:0] pq [NC];
  logic [W-1:0]    p_nxt [NC];
  logic [W-1:0]    s4_p_r [NC];
  side_t           s4_side_r;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      pq[c]    = {{QW{1'b0}}, s3_t3_r[c]} * {{W{1'b0}}, s3_q_r[c]};
      p_nxt[c] = (pq[c][W+QW-1:FB] > {4'b0000, ONE}) ? ONE : pq[c][FB+W-1:FB];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_p_r    <= p_nxt;
      s4_side_r <= s3_side_r;
    end
  end

  // stage 5: channel 2 fade, channel 0 ramp, back to Q1.15
  logic [2*W-1:0]   pf2, pf0;
  logic [W-1:0]     c_val [NC];
  logic [W+IOW-1:0] c_wide [NC];
  logic [IOW-1:0]   o_nxt [NC];
  logic [IOW-1:0]   o_r [NC];

  always_comb begin
    pf2 = {{W{1'b0}}, s4_p_r[gthc_pkg::CH_2]} * {{W{1'b0}}, s4_side_r.f2};
    pf0 = {{W{1'b0}}, s4_p_r[gthc_pkg::CH_0]} * {{W{1'b0}}, s4_side_r.sc0};
    c_val[gthc_pkg::CH_2] = s4_side_r.hi2 ? pf2[FB+W-1:FB] : s4_p_r[gthc_pkg::CH_2];
    c_val[gthc_pkg::CH_1] = s4_p_r[gthc_pkg::CH_1];
    c_val[gthc_pkg::CH_0] = s4_side_r.lo0 ? pf0[FB+W-1:FB] : s4_p_r[gthc_pkg::CH_0];
    for (int c = 0; c < NC; c++) begin
      c_wide[c] = ({{IOW{1'b0}}, c_val[c]} >> UP_SH) << DN_SH;
      o_nxt[c]  = c_wide[c][IOW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      o_r <= o_nxt;
    end
  end

  assign out_chan_0 = o_r[gthc_pkg::CH_0];
  assign out_chan_1 = o_r[gthc_pkg::CH_1];
  assign out_chan_2 = o_r[gthc_pkg::CH_2];

  // any channel above one
  logic chan_over;

  assign chan_over = (out_chan_0 > gthc_pkg::GREY_ONE) ||
                     (out_chan_1 > gthc_pkg::GREY_ONE) ||
                     (out_chan_2 > gthc_pkg::GREY_ONE);

  // checks
  `GTHC_ASSERT_NEVER(a_chan_range, clk, rst_n, out_valid && chan_over)
  `GTHC_ASSERT(a_stall_only_full, clk, rst_n, in_stall |-> (&v_r))
  `GTHC_ASSERT(a_last_handoff, clk, rst_n, (v_r[NS-2] && rdy[NS-1]) |=> v_r[NS-1])

endmodule

FILE: verif/grey_to_heat_colormap_top_tb.sv
// self-checking testbench for the grey to heat colormap pipeline
// depends on gthc_pkg.sv and grey_to_heat_colormap_top.sv (instance dut)
`timescale 1ns / 100ps

module grey_to_heat_colormap_top_tb;

  // internal fixed point width, matches the block's default parameter
  localparam int FRAC  = 15;
  localparam int UP_SH = (FRAC >= gthc_pkg::IO_FRAC) ? FRAC - gthc_pkg::IO_FRAC : 0;
  localparam int DN_SH = (FRAC < gthc_pkg::IO_FRAC) ? gthc_pkg::IO_FRAC - FRAC : 0;

  typedef logic [63:0] fx_t;

  localparam fx_t ONE_FX = fx_t'(1) << FRAC;
  localparam fx_t K_0P3  = (3 * ONE_FX + 5) / 10;
  localparam fx_t K_0P5  = ONE_FX / 2;
  localparam fx_t K_0P7  = (7 * ONE_FX + 5) / 10;
  localparam fx_t K_0P9  = (9 * ONE_FX + 5) / 10;
  localparam fx_t K_1P1  = (11 * ONE_FX + 5) / 10;
  localparam fx_t R_0P3  = (20 * ONE_FX + 3) / 6;
  localparam fx_t R_0P7  = (20 * ONE_FX + 7) / 14;

  localparam int RAND_ITEMS  = 1300;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    gthc_pkg::io_word_t chan_0;
    gthc_pkg::io_word_t chan_1;
    gthc_pkg::io_word_t chan_2;
  } heat_px_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  gthc_pkg::io_word_t in_grey = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  gthc_pkg::io_word_t out_chan_0;
  gthc_pkg::io_word_t out_chan_1;
  gthc_pkg::io_word_t out_chan_2;

  gthc_pkg::io_word_t grey_pending[$];
  heat_px_t           heat_due[$];
  heat_px_t           heat_head;

  int total_items;
  int grey_taken;
  int over_one_taken;
  int pixels_seen;
  int fail_count;
  int pace;
  int tx_idle_pct;
  int rx_idle_pct;
  int quiet_cycles;

  grey_to_heat_colormap_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_grey   (in_grey),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_chan_0(out_chan_0),
    .out_chan_1(out_chan_1),
    .out_chan_2(out_chan_2)
  );

  always #2 clk = ~clk;

  // fixed point helpers
  function automatic fx_t clip_unit(input fx_t v);
    return (v > ONE_FX) ? ONE_FX : v;
  endfunction

  function automatic fx_t fx_mul(input fx_t a, input fx_t b);
    return (a * b) >> FRAC;
  endfunction

  // quintic smoothstep of a t already clamped to 0..1
  function automatic fx_t smooth5(input fx_t t);
    fx_t t3;
    fx_t q;
    t3 = fx_mul(fx_mul(t, t), t);
    q  = 10 * ONE_FX - fx_mul(t, 15 * ONE_FX - 6 * t);
    return clip_unit(fx_mul(t3, q));
  endfunction

  function automatic gthc_pkg::io_word_t to_io_word(input fx_t v);
    fx_t w;
    w = (clip_unit(v) >> UP_SH) << DN_SH;
    return gthc_pkg::io_word_t'(w & 64'hFFFF);
  endfunction

  // expected color of one grey level
  function automatic heat_px_t heat_of_grey(input gthc_pkg::io_word_t grey);
    fx_t g;
    fx_t t;
    fx_t f;
    fx_t c0;
    fx_t c1;
    fx_t c2;
    heat_px_t px;
    g = (grey > gthc_pkg::GREY_ONE) ? fx_t'(gthc_pkg::GREY_ONE) : fx_t'(grey);
    g = (g << UP_SH) >> DN_SH;

    // red rises past one half, fades out above 0.9
    t  = (g <= K_0P5) ? fx_t'(0) : clip_unit(fx_mul(g - K_0P5, R_0P3));
    c2 = smooth5(t);
    if (g >= K_0P9) begin
      f  = (g < K_1P1) ? clip_unit((K_1P1 - g) * 5) : fx_t'(0);
      c2 = fx_mul(c2, f);
    end

    // green peaks at 0.7
    if (g > K_0P7) begin
      t = clip_unit(fx_mul(ONE_FX - g, R_0P3));
    end else begin
      t = clip_unit(fx_mul(g, R_0P7));
    end
    c1 = smooth5(t);

    // blue falls with g, ramped in below 0.3
    c0 = smooth5(ONE_FX - g);
    if (g <= K_0P3) begin
      c0 = fx_mul(c0, clip_unit(fx_mul(g, R_0P3)));
    end

    px.chan_0 = to_io_word(c0);
    px.chan_1 = to_io_word(c1);
    px.chan_2 = to_io_word(c2);
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("mismatch: %s", msg);
  endtask

  // idle rates per phase of the run
  always_comb begin
    unique case (pace)
      0: begin
        tx_idle_pct = 24;
        rx_idle_pct = 67;
      end
      1: begin
        tx_idle_pct = 67;
        rx_idle_pct = 24;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  end

  // grey driver: holds an item until taken, then loads the next or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_grey  <= '0;
      pace     <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        heat_due.push_back(heat_of_grey(in_grey));
        grey_taken++;
        if (in_grey > gthc_pkg::GREY_ONE) begin
          over_one_taken++;
        end
        pace <= (grey_taken * 3 < total_items) ? 0 :
                (grey_taken * 3 < 2 * total_items) ? 1 : 2;
      end
      if (!in_valid || !in_stall) begin
        if (grey_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_grey  <= grey_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // color monitor: checks each taken pixel against the oldest expected one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        pixels_seen++;
        if (heat_due.size() == 0) begin
          report_mismatch($sformatf("pixel %0d arrived with none expected", pixels_seen));
        end else begin
          heat_head = heat_due.pop_front();
          if (out_chan_0 !== heat_head.chan_0) begin
            report_mismatch($sformatf("pixel %0d chan_0 got %0d want %0d",
                                      pixels_seen, out_chan_0, heat_head.chan_0));
          end
          if (out_chan_1 !== heat_head.chan_1) begin
            report_mismatch($sformatf("pixel %0d chan_1 got %0d want %0d",
                                      pixels_seen, out_chan_1, heat_head.chan_1));
          end
          if (out_chan_2 !== heat_head.chan_2) begin
            report_mismatch($sformatf("pixel %0d chan_2 got %0d want %0d",
                                      pixels_seen, out_chan_2, heat_head.chan_2));
          end
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int edges[7];
    int i;
    int pick;
    int v;
    edges = '{0, int'(K_0P3), int'(K_0P5), 26214, int'(K_0P7), int'(K_0P9), 32768};

    // directed: range ends, branch thresholds, saturation above one
    grey_pending = '{16'd0, 16'd1, 16'd2, 16'd4915, 16'd9830, 16'd9831,
                     16'd16384, 16'd16385, 16'd22938, 16'd22939, 16'd26214,
                     16'd29490, 16'd29491, 16'd32767, 16'd32768, 16'd32769,
                     16'd40000, 16'h5555, 16'hAAAA, 16'hFFFF};

    // random: mostly in range, some around thresholds, some full width
    for (i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        v = $urandom_range(32768);
      end else if (pick < 85) begin
        v = edges[$urandom_range(6)] + int'($urandom_range(8)) - 4;
        if (v < 0) begin
          v = 0;
        end
      end else begin
        v = $urandom & 16'hFFFF;
      end
      grey_pending.push_back(gthc_pkg::io_word_t'(v));
    end
    total_items = grey_pending.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (grey_taken < total_items) @(posedge clk);
    while (heat_due.size() > 0) @(posedge clk);
    repeat (2 * gthc_pkg::NUM_STG) @(posedge clk);

    if (heat_due.size() != 0) begin
      report_mismatch($sformatf("%0d pixels never arrived", heat_due.size()));
    end

    $display("covered %0d grey levels (%0d above one) and %0d colored pixels,",
             grey_taken, over_one_taken, pixels_seen);
    $display("with sender and receiver idling in turn, then at full rate; %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
